/* design/reh_pkg.sv */
// Shared types, widths and constants for the request envelope header checker.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package reh_pkg;

  localparam int ENVELOPE_BYTES = 32;
  localparam int POS_W          = $clog2(ENVELOPE_BYTES);
  localparam int BYTE_W         = 8;
  localparam int WORD_W         = 32;
  localparam int ID_W           = 64;
  localparam int SIZE_W         = 33;
  // 32 plus four 32-bit section sizes fits in 35 bits
  localparam int SUM_W          = 35;
  localparam int STATUS_W       = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(ENVELOPE_BYTES);

  localparam logic [WORD_W-1:0] HEADER_LIMIT_RST = 32'd65536;
  localparam logic [WORD_W-1:0] METHOD_LIMIT_RST = 32'd32;
  localparam logic [WORD_W-1:0] TARGET_LIMIT_RST = 32'd2048;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LIMIT = 2'd2;

  localparam logic [BYTE_W-1:0] MAGIC_S   = 8'h53;  // 'S'
  localparam logic [BYTE_W-1:0] MAGIC_E   = 8'h45;  // 'E'
  localparam logic [BYTE_W-1:0] MAGIC_H   = 8'h48;  // 'H'
  localparam logic [BYTE_W-1:0] MAGIC_VER = 8'h01;

  // Header region, selected by byte position bits [4:2]
  typedef enum logic [2:0] {
    RG_MAGIC   = 3'd0,
    RG_LENGTH  = 3'd1,
    RG_ID_LO   = 3'd2,
    RG_ID_HI   = 3'd3,
    RG_METHOD  = 3'd4,
    RG_TARGET  = 3'd5,
    RG_HEADERS = 3'd6,
    RG_BODY    = 3'd7
  } reh_region_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 4'd0,
    ST_SIZE    = 4'd1,
    ST_MAGIC   = 4'd2,
    ST_LENGTH  = 4'd3,
    ST_ZERO_ID = 4'd4,
    ST_SUM     = 4'd5,
    ST_METHOD  = 4'd6,
    ST_TARGET  = 4'd7,
    ST_HEADERS = 4'd8
  } reh_status_t;

  typedef struct packed {
    logic [WORD_W-1:0] header_limit;
    logic [WORD_W-1:0] method_limit;
    logic [WORD_W-1:0] target_limit;
  } reh_limits_t;

  // Everything the checks need once an envelope header has ended
  typedef struct packed {
    logic              complete;
    logic              magic_good;
    logic [SIZE_W-1:0] size;
    logic [WORD_W-1:0] length;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] method;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] headers;
    logic [WORD_W-1:0] body;
    logic [SUM_W-1:0]  total;
    logic [WORD_W-1:0] target_start;
    logic [WORD_W-1:0] headers_start;
    logic [WORD_W-1:0] body_start;
  } reh_frame_t;

  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      2'd0:    b = MAGIC_S;
      2'd1:    b = MAGIC_E;
      2'd2:    b = MAGIC_H;
      default: b = MAGIC_VER;
    endcase
    return b;
  endfunction

endpackage

/* design/reh_envelope_if.sv */
// Input channel of the header checker: one envelope byte per item.
// Depends on reh_pkg for field widths.
`timescale 1ns / 1ps

interface reh_envelope_if import reh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  logic [SIZE_W-1:0] payload_size;
  logic              last_byte;

  modport source (output valid, output header_byte, output payload_size,
                  output last_byte, input ready);
  modport sink   (input valid, input header_byte, input payload_size,
                  input last_byte, output ready);
endinterface

/* design/reh_result_if.sv */
// Output channel of the header checker: status, request id, sizes, offsets.
// Depends on reh_pkg for field widths.
`timescale 1ns / 1ps

interface reh_result_if import reh_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     req_id;
  logic [WORD_W-1:0]   method_length;
  logic [WORD_W-1:0]   target_length;
  logic [WORD_W-1:0]   headers_length;
  logic [WORD_W-1:0]   body_length;
  logic [WORD_W-1:0]   target_start;
  logic [WORD_W-1:0]   headers_start;
  logic [WORD_W-1:0]   body_start;

  modport source (output valid, output status, output req_id,
                  output method_length, output target_length,
                  output headers_length, output body_length,
                  output target_start, output headers_start,
                  output body_start, input ready);
  modport sink   (input valid, input status, input req_id,
                  input method_length, input target_length,
                  input headers_length, input body_length,
                  input target_start, input headers_start,
                  input body_start, output ready);
endinterface

/* design/reh_assembler.sv */
// Byte-wise assembly of the envelope header words and running section sum.
// Depends on reh_pkg and reh_envelope_if; hands a frame register to the judge.
`timescale 1ns / 1ps

module reh_assembler import reh_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  reh_envelope_if.sink   envelope,
  output logic           frame_valid,
  output reh_frame_t     frame,
  input  logic           frame_ready
);

  logic [POS_W-1:0]  pos;
  logic              magic_good;
  logic [SUM_W-1:0]  sum;
  logic [WORD_W-1:0] length_word;
  logic [ID_W-1:0]   id_word;
  logic [WORD_W-1:0] method_word;
  logic [WORD_W-1:0] target_word;
  logic [WORD_W-1:0] headers_word;
  logic [WORD_W-1:0] body_word;
  logic [WORD_W-1:0] target_start;
  logic [WORD_W-1:0] headers_start;
  logic [WORD_W-1:0] body_start;

  logic              magic_good_next;
  logic [SUM_W-1:0]  sum_next;
  logic [WORD_W-1:0] length_word_next;
  logic [ID_W-1:0]   id_word_next;
  logic [WORD_W-1:0] method_word_next;
  logic [WORD_W-1:0] target_word_next;
  logic [WORD_W-1:0] headers_word_next;
  logic [WORD_W-1:0] body_word_next;

  logic              accept;
  logic              is_last_pos;
  logic              is_final;
  logic              lane_top;
  logic [4:0]        lane_base;
  logic [5:0]        id_base;
  logic [WORD_W-1:0] shifted;
  reh_region_t       region;

  assign envelope.ready = !frame_valid || frame_ready;
  assign accept         = envelope.valid && envelope.ready;
  assign is_last_pos    = (pos == POS_W'(ENVELOPE_BYTES - 1));
  assign is_final       = is_last_pos || envelope.last_byte;
  assign lane_top       = (pos[1:0] == 2'd3);
  assign lane_base      = {pos[1:0], 3'b000};
  assign id_base        = {pos[2:0], 3'b000};
  assign region         = reh_region_t'(pos[POS_W-1:2]);
  assign shifted        = WORD_W'(envelope.header_byte) << lane_base;

  always_comb begin
    magic_good_next   = magic_good;
    sum_next          = sum;
    length_word_next  = length_word;
    id_word_next      = id_word;
    method_word_next  = method_word;
    target_word_next  = target_word;
    headers_word_next = headers_word;
    body_word_next    = body_word;
    unique case (region)
      RG_MAGIC: begin
        if (envelope.header_byte != magic_byte(pos[1:0])) magic_good_next = 1'b0;
      end
      RG_LENGTH: length_word_next[lane_base +: BYTE_W] = envelope.header_byte;
      RG_ID_LO, RG_ID_HI: id_word_next[id_base +: BYTE_W] = envelope.header_byte;
      RG_METHOD: begin
        method_word_next[lane_base +: BYTE_W] = envelope.header_byte;
        sum_next = sum + SUM_W'(shifted);
      end
      RG_TARGET: begin
        target_word_next[lane_base +: BYTE_W] = envelope.header_byte;
        sum_next = sum + SUM_W'(shifted);
      end
      RG_HEADERS: begin
        headers_word_next[lane_base +: BYTE_W] = envelope.header_byte;
        sum_next = sum + SUM_W'(shifted);
      end
      RG_BODY: begin
        body_word_next[lane_base +: BYTE_W] = envelope.header_byte;
        sum_next = sum + SUM_W'(shifted);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      magic_good  <= 1'b1;
      sum         <= SUM_INIT;
      frame_valid <= 1'b0;
    end else begin
      if (envelope.ready) frame_valid <= accept && is_final;
      if (accept) begin
        if (is_final) begin
          pos        <= '0;
          magic_good <= 1'b1;
          sum        <= SUM_INIT;
        end else begin
          pos        <= pos + 1'b1;
          magic_good <= magic_good_next;
          sum        <= sum_next;
        end
      end
    end
  end

  // Words need no clearing: a complete header overwrites every byte lane.
  always_ff @(posedge clk) begin
    if (accept) begin
      length_word  <= length_word_next;
      id_word      <= id_word_next;
      method_word  <= method_word_next;
      target_word  <= target_word_next;
      headers_word <= headers_word_next;
      body_word    <= body_word_next;
      // section offsets are the running sum as each size word completes
      if (lane_top && region == RG_METHOD)  target_start  <= sum_next[WORD_W-1:0];
      if (lane_top && region == RG_TARGET)  headers_start <= sum_next[WORD_W-1:0];
      if (lane_top && region == RG_HEADERS) body_start    <= sum_next[WORD_W-1:0];
      if (is_final) begin
        frame.complete      <= is_last_pos;
        frame.magic_good    <= magic_good_next;
        frame.size          <= envelope.payload_size;
        frame.length        <= length_word_next;
        frame.id            <= id_word_next;
        frame.method        <= method_word_next;
        frame.target        <= target_word_next;
        frame.headers       <= headers_word_next;
        frame.body          <= body_word_next;
        frame.total         <= sum_next;
        frame.target_start  <= target_start;
        frame.headers_start <= headers_start;
        frame.body_start    <= body_start;
      end
    end
  end

endmodule

/* design/reh_judge.sv */
// Header checks in priority order and the result register.
// Depends on reh_pkg and reh_result_if; fed by reh_assembler.
`timescale 1ns / 1ps

module reh_judge import reh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         frame_valid,
  input  reh_frame_t   frame,
  output logic         frame_ready,
  input  reh_limits_t  limits,
  reh_result_if.source result
);

  reh_status_t st;
  logic        ok;

  assign frame_ready = !result.valid || result.ready;

  always_comb begin
    if (!frame.complete || frame.size < SIZE_W'(ENVELOPE_BYTES) || frame.size[SIZE_W-1]) begin
      st = ST_SIZE;
    end else if (!frame.magic_good) begin
      st = ST_MAGIC;
    end else if ({1'b0, frame.length} != frame.size) begin
      st = ST_LENGTH;
    end else if (frame.id == '0) begin
      st = ST_ZERO_ID;
    end else if (frame.total != {2'b00, frame.size}) begin
      st = ST_SUM;
    end else if (frame.method == '0 || frame.method > limits.method_limit) begin
      st = ST_METHOD;
    end else if (frame.target == '0 || frame.target > limits.target_limit) begin
      st = ST_TARGET;
    end else if (frame.headers > limits.header_limit) begin
      st = ST_HEADERS;
    end else begin
      st = ST_OK;
    end
  end

  assign ok = (st == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (frame_ready) begin
      result.valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      result.status         <= STATUS_W'(st);
      result.req_id         <= ok ? frame.id            : '0;
      result.method_length  <= ok ? frame.method        : '0;
      result.target_length  <= ok ? frame.target        : '0;
      result.headers_length <= ok ? frame.headers       : '0;
      result.body_length    <= ok ? frame.body          : '0;
      result.target_start   <= ok ? frame.target_start  : '0;
      result.headers_start  <= ok ? frame.headers_start : '0;
      result.body_start     <= ok ? frame.body_start    : '0;
    end
  end

endmodule

/* design/request_envelope_header_checker.sv */
// Request envelope header checker, top level.
// Takes one header byte per cycle, back to back, when the result side keeps up.
// The byte that ends the header (32nd byte or an early last byte) fills the
// assembled frame register, and the judged result then moves into the result
// register. Synchronous reset clears the byte position, magic flag,
// running sum and valid flags, and loads the limit registers with their defaults.
`timescale 1ns / 1ps

module request_envelope_header_checker import reh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  reh_envelope_if.sink         envelope,
  reh_result_if.source         result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  reh_limits_t limits;
  reh_frame_t  frame;
  logic        frame_valid;
  logic        frame_ready;

  // index beyond the register list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.header_limit <= HEADER_LIMIT_RST;
      limits.method_limit <= METHOD_LIMIT_RST;
      limits.target_limit <= TARGET_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEADER_LIMIT: limits.header_limit <= cfg_data;
        CFG_METHOD_LIMIT: limits.method_limit <= cfg_data;
        CFG_TARGET_LIMIT: limits.target_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  reh_assembler u_assembler (
    .clk         (clk),
    .rst         (rst),
    .envelope    (envelope),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready)
  );

  reh_judge u_judge (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready),
    .limits      (limits),
    .result      (result)
  );

endmodule

/* tb/sv/tb_request_envelope_header_checker.sv */
// Self-checking testbench for request_envelope_header_checker: drives envelope bytes,
// predicts each status and section layout, and checks every result in order.
// Depends on reh_pkg, reh_envelope_if and reh_result_if from the design.
`timescale 1ns / 1ps

module tb_request_envelope_header_checker;
  import reh_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 8;
  localparam int FLAW_KINDS  = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    FL_NONE, FL_SIZE_LOW, FL_SIZE_HIGH, FL_MAGIC, FL_LENGTH, FL_ZERO_ID, FL_SUM,
    FL_METHOD_ZERO, FL_METHOD_OVER, FL_TARGET_ZERO, FL_TARGET_OVER, FL_HEADERS_OVER,
    FL_EARLY
  } envelope_flaw_t;

  typedef struct packed {
    reh_status_t       status;
    logic [ID_W-1:0]   req_id;
    logic [WORD_W-1:0] method_length;
    logic [WORD_W-1:0] target_length;
    logic [WORD_W-1:0] headers_length;
    logic [WORD_W-1:0] body_length;
    logic [WORD_W-1:0] target_start;
    logic [WORD_W-1:0] headers_start;
    logic [WORD_W-1:0] body_start;
  } header_verdict_t;

  class header_verdict_tracker;
    logic [WORD_W-1:0] header_limit, method_limit, target_limit;
    int unsigned       position;
    bit                magic_ok;
    logic [WORD_W-1:0] length_w, method_w, target_w, headers_w, body_w;
    logic [ID_W-1:0]   id_w;
    header_verdict_t   verdicts_due[$];
    int unsigned       failures;

    function new();
      header_limit = HEADER_LIMIT_RST;
      method_limit = METHOD_LIMIT_RST;
      target_limit = TARGET_LIMIT_RST;
      failures     = 0;
      restart();
    endfunction

    function void restart();
      position  = 0;
      magic_ok  = 1'b1;
      length_w  = '0;
      id_w      = '0;
      method_w  = '0;
      target_w  = '0;
      headers_w = '0;
      body_w    = '0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        CFG_HEADER_LIMIT: header_limit = value;
        CFG_METHOD_LIMIT: method_limit = value;
        CFG_TARGET_LIMIT: target_limit = value;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic [SIZE_W-1:0] size, logic ends);
      header_verdict_t   v;
      reh_status_t       st;
      logic [WORD_W-1:0] magic_word;
      logic [63:0]       total;
      int unsigned       lane;
      magic_word = {MAGIC_VER, MAGIC_H, MAGIC_E, MAGIC_S};
      if (position < ENVELOPE_BYTES) begin
        lane = (position % 4) * 8;
        case (reh_region_t'(3'(position / 4)))
          RG_MAGIC:   if (b != magic_word[lane +: 8]) magic_ok = 1'b0;
          RG_LENGTH:  length_w[lane +: 8] = b;
          RG_ID_LO:   id_w[lane +: 8] = b;
          RG_ID_HI:   id_w[32 + lane +: 8] = b;
          RG_METHOD:  method_w[lane +: 8] = b;
          RG_TARGET:  target_w[lane +: 8] = b;
          RG_HEADERS: headers_w[lane +: 8] = b;
          default:    body_w[lane +: 8] = b;
        endcase
        position++;
      end
      if (position < ENVELOPE_BYTES && !ends) return;

      total = 64'(ENVELOPE_BYTES) + method_w + target_w + headers_w + body_w;
      if (position < ENVELOPE_BYTES || size < SIZE_W'(ENVELOPE_BYTES) || size[SIZE_W-1])
        st = ST_SIZE;
      else if (!magic_ok) st = ST_MAGIC;
      else if ({1'b0, length_w} != size) st = ST_LENGTH;
      else if (id_w == '0) st = ST_ZERO_ID;
      else if (total != 64'(size)) st = ST_SUM;
      else if (method_w == '0 || method_w > method_limit) st = ST_METHOD;
      else if (target_w == '0 || target_w > target_limit) st = ST_TARGET;
      else if (headers_w > header_limit) st = ST_HEADERS;
      else st = ST_OK;

      v = '0;
      v.status = st;
      if (st == ST_OK) begin
        v.req_id         = id_w;
        v.method_length  = method_w;
        v.target_length  = target_w;
        v.headers_length = headers_w;
        v.body_length    = body_w;
        v.target_start   = WORD_W'(ENVELOPE_BYTES) + method_w;
        v.headers_start  = v.target_start + target_w;
        v.body_start     = v.headers_start + headers_w;
      end
      verdicts_due.push_back(v);
      restart();
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        failures++;
      end
    endfunction

    function void check_verdict(header_verdict_t got);
      header_verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, got.status);
        failures++;
        return;
      end
      want = verdicts_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("req_id", want.req_id, got.req_id);
      compare_field("method_length", want.method_length, got.method_length);
      compare_field("target_length", want.target_length, got.target_length);
      compare_field("headers_length", want.headers_length, got.headers_length);
      compare_field("body_length", want.body_length, got.body_length);
      compare_field("target_start", want.target_start, got.target_start);
      compare_field("headers_start", want.headers_start, got.headers_start);
      compare_field("body_start", want.body_start, got.body_start);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  reh_envelope_if envelope_ch ();
  reh_result_if   result_ch ();

  header_verdict_tracker tracker;
  int sender_idle_pct;
  int receiver_stall_pct;
  int bytes_sent;
  int stalled_cycles;

  request_envelope_header_checker dut (
    .clk       (clk),
    .rst       (rst),
    .envelope  (envelope_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    header_verdict_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status         = reh_status_t'(result_ch.status);
      got.req_id         = result_ch.req_id;
      got.method_length  = result_ch.method_length;
      got.target_length  = result_ch.target_length;
      got.headers_length = result_ch.headers_length;
      got.body_length    = result_ch.body_length;
      got.target_start   = result_ch.target_start;
      got.headers_start  = result_ch.headers_start;
      got.body_start     = result_ch.body_start;
      tracker.check_verdict(got);
    end
  end

  // Ends the run if neither channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (envelope_ch.valid && envelope_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] pick_upto(input logic [WORD_W-1:0] lim);
    logic [63:0] span;
    logic [63:0] r;
    span = {32'd0, lim} + 64'd1;
    case ($urandom_range(0, 3))
      0, 1:    r = 64'($urandom_range(0, 40)) % span;
      2:       r = {32'd0, lim} - (64'($urandom_range(0, 2)) % span);
      default: r = {$urandom, $urandom} % span;
    endcase
    return r[WORD_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] any_size();
    return SIZE_W'({$urandom, $urandom});
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [SIZE_W-1:0] size,
                           input logic ends);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      envelope_ch.valid <= 1'b0;
      @(negedge clk);
    end
    envelope_ch.valid        <= 1'b1;
    envelope_ch.header_byte  <= b;
    envelope_ch.payload_size <= size;
    envelope_ch.last_byte    <= ends;
    @(posedge clk);
    while (!envelope_ch.ready) @(posedge clk);
    tracker.note_byte(b, size, ends);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    envelope_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.verdicts_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    tracker.set_limit(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_limits(input int phase);
    logic [WORD_W-1:0] hl, ml, tl;
    case (phase)
      1: begin
        hl = '0;
        ml = 32'd1;
        tl = 32'd1;
      end
      2: begin
        hl = '1;
        ml = '1;
        tl = '1;
      end
      3: begin
        hl = HEADER_LIMIT_RST;
        ml = METHOD_LIMIT_RST;
        tl = TARGET_LIMIT_RST;
      end
      default: begin
        hl = $urandom_range(0, 1) ? 32'($urandom_range(0, 300)) : 32'($urandom);
        ml = 32'($urandom_range(1, 100));
        tl = $urandom_range(0, 1) ? 32'($urandom_range(1, 3000)) : (32'($urandom) | 32'd1);
      end
    endcase
    write_reg(CFG_HEADER_LIMIT, hl);
    write_reg(CFG_METHOD_LIMIT, ml);
    write_reg(CFG_TARGET_LIMIT, tl);
    write_reg(CFG_UNUSED, 32'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Builds one envelope header, well formed apart from the requested flaw
  task automatic send_envelope(input envelope_flaw_t flaw);
    logic [WORD_W-1:0] m, t, h, b, len_w, hl, ml, tl;
    logic [ID_W-1:0]   id;
    logic [63:0]       total;
    logic [SIZE_W-1:0] size;
    logic [BYTE_W-1:0] hdr [ENVELOPE_BYTES];
    int                n;
    hl = tracker.header_limit;
    ml = tracker.method_limit;
    tl = tracker.target_limit;
    m = 32'd1 + pick_upto(ml - 32'd1);
    t = 32'd1 + pick_upto(tl - 32'd1);
    h = pick_upto(hl);
    while (64'(ENVELOPE_BYTES) + m + t + h > 64'hFFFF_FFFF) begin
      m = (m >> 1) + 32'd1;
      t = (t >> 1) + 32'd1;
      h = h >> 1;
    end
    b = pick_upto(32'hFFFF_FFFF - WORD_W'(ENVELOPE_BYTES) - m - t - h);
    id = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       id = '1;
      1:       id = 64'd1;
      default: ;
    endcase
    if (id == '0) id = 64'd1;

    case (flaw)
      FL_METHOD_ZERO:  m = '0;
      FL_METHOD_OVER:  if (ml != '1) m = ml + 32'd1;
      FL_TARGET_ZERO:  t = '0;
      FL_TARGET_OVER:  if (tl != '1) t = tl + 32'd1;
      FL_HEADERS_OVER: if (hl != '1) h = hl + 32'd1;
      default: ;
    endcase
    total = 64'(ENVELOPE_BYTES) + m + t + h + b;
    if (total > 64'hFFFF_FFFF) begin
      b = '0;
      total = 64'(ENVELOPE_BYTES) + m + t + h;
    end
    size  = total[SIZE_W-1:0];
    len_w = size[WORD_W-1:0];

    case (flaw)
      FL_SIZE_LOW: begin
        size  = SIZE_W'($urandom_range(0, ENVELOPE_BYTES - 1));
        len_w = size[WORD_W-1:0];
      end
      FL_SIZE_HIGH: begin
        size  = {1'b1, 32'($urandom)};
        len_w = size[WORD_W-1:0];
      end
      FL_LENGTH:  len_w = len_w ^ (32'($urandom) | (32'd1 << $urandom_range(0, 31)));
      FL_ZERO_ID: id = '0;
      FL_SUM:     b = b + 32'($urandom_range(1, 1000));
      default: ;
    endcase

    hdr[0] = MAGIC_S;
    hdr[1] = MAGIC_E;
    hdr[2] = MAGIC_H;
    hdr[3] = MAGIC_VER;
    for (int i = 0; i < 4; i++) begin
      hdr[4 + i]  = len_w[8*i +: 8];
      hdr[16 + i] = m[8*i +: 8];
      hdr[20 + i] = t[8*i +: 8];
      hdr[24 + i] = h[8*i +: 8];
      hdr[28 + i] = b[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) hdr[8 + i] = id[8*i +: 8];
    if (flaw == FL_MAGIC) begin
      n = $urandom_range(0, 3);
      hdr[n] = hdr[n] ^ 8'($urandom_range(1, 255));
    end

    n = (flaw == FL_EARLY) ? $urandom_range(1, ENVELOPE_BYTES - 1) : ENVELOPE_BYTES;
    for (int i = 0; i < n; i++) begin
      // only the size given with the closing byte counts
      if (i == n - 1)
        send_byte(hdr[i], size, (flaw == FL_EARLY) || ($urandom_range(0, 1) == 1));
      else
        send_byte(hdr[i], ($urandom_range(0, 4) == 0) ? any_size() : size, 1'b0);
    end
  endtask

  task automatic send_noise();
    logic ends;
    ends = 1'b0;
    for (int i = 0; i < ENVELOPE_BYTES && !ends; i++) begin
      ends = ($urandom_range(0, 11) == 0);
      send_byte(8'($urandom), any_size(), ends);
    end
  endtask

  initial begin
    int envelopes;
    int phase_start;
    int pick;
    tracker                  = new();
    rst                      = 1'b1;
    cfg_write                = 1'b0;
    cfg_index                = CFG_HEADER_LIMIT;
    cfg_data                 = '0;
    envelope_ch.valid        = 1'b0;
    envelope_ch.header_byte  = '0;
    envelope_ch.payload_size = '0;
    envelope_ch.last_byte    = 1'b0;
    sender_idle_pct          = 0;
    receiver_stall_pct       = 0;
    bytes_sent               = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone closing byte at the field extremes, then a two-byte early end
    send_byte(8'hFF, '1, 1'b1);
    send_byte(8'h00, '0, 1'b0);
    send_byte(8'h00, '0, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
        default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
      endcase
      if (phase != 0) begin
        drain_results();
        // block may still be finishing internally after the last result
        repeat (4) @(negedge clk);
        apply_limits(phase);
      end
      envelopes   = 0;
      phase_start = bytes_sent;
      while (envelopes < 3 || bytes_sent - phase_start < 80) begin
        if (envelopes == 2) drain_results();
        pick = $urandom_range(0, 99);
        if (phase == 0 && envelopes < FLAW_KINDS)
          send_envelope(envelope_flaw_t'(envelopes));
        else if (pick < 45)
          send_envelope(FL_NONE);
        else if (pick < 80)
          send_envelope(envelope_flaw_t'($urandom_range(1, FLAW_KINDS - 2)));
        else if (pick < 90)
          send_envelope(FL_EARLY);
        else
          send_noise();
        envelopes++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (tracker.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/reh_pkg.sv
design/reh_envelope_if.sv
design/reh_result_if.sv
design/reh_assembler.sv
design/reh_judge.sv
design/request_envelope_header_checker.sv
tb/sv/tb_request_envelope_header_checker.sv
